// ===== hw/rtl/trfa_pkg.sv =====
`timescale 1ns / 1ps

package trfa_pkg;

	localparam int BUF_GRANULES_DEF    = 1024;
	localparam int HEADER_GRANULES_DEF = 4;

	localparam int OUT_POS_W   = 10;
	localparam int PAYLOAD_W   = 11;
	localparam int DROP_W      = 9;
	localparam int WRITERS_W   = 8;

	localparam logic [DROP_W-1:0]    DROP_MAX    = '1;
	localparam logic [WRITERS_W-1:0] WRITERS_MAX = '1;

	typedef enum logic [1:0] {
		STAT_RESERVED  = 2'd0,
		STAT_REFUSED   = 2'd1,
		STAT_COMMITTED = 2'd2,
		STAT_NO_WRITER = 2'd3
	} status_t;

	typedef enum logic {
		ACT_RESERVE = 1'b0,
		ACT_COMMIT  = 1'b1
	} action_t;

endpackage

// ===== hw/rtl/trfa_ram.sv =====
`timescale 1ns / 1ps

module trfa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/trace_ring_frame_allocator.sv =====
`timescale 1ns / 1ps

// Reserve/commit allocator for a circular trace store counted in granules.
// Request channel (req_valid/req_ready): action selects reserve or commit;
// a reserve asks for HEADER_GRANULES plus payload_granules, a commit names
// the header position of a frame reserved earlier.
// Response channel (rsp_valid/rsp_ready): one response per request, with the
// status, the granted position, the count of dropped oldest frames and the
// read, committed and write pointers after the request.
// Frame sizes live in one single-port-read RAM with registered read data.
// Path: a commit responds straight from S_IDLE, or by way of S_CMT when it
// must look up the committed frame's size. A reserve refused at a full writer
// count responds straight from S_IDLE, any other reserve by way of S_EVAL,
// which it enters again after each tail pad and, through S_DROP, after each
// dropped frame (the size RAM read of the oldest frame needs S_DROP).
// One request is in flight at a time; the next request is taken in the cycle
// its predecessor's response transfers, or later.
// Reset clears all pointers and the writer count; the size RAM is not
// cleared, an entry is only read after it has been written.
// A stalled response holds its payload and blocks new requests.

module trace_ring_frame_allocator #(
	parameter int BUF_GRANULES    = trfa_pkg::BUF_GRANULES_DEF,
	parameter int HEADER_GRANULES = trfa_pkg::HEADER_GRANULES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            action,
	input  logic [trfa_pkg::PAYLOAD_W-1:0]  payload_granules,
	input  logic [trfa_pkg::OUT_POS_W-1:0]  commit_pos,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [1:0]                      status,
	output logic [trfa_pkg::OUT_POS_W-1:0]  frame_pos,
	output logic [trfa_pkg::DROP_W-1:0]     frames_dropped,
	output logic [trfa_pkg::OUT_POS_W-1:0]  read_pos,
	output logic [trfa_pkg::OUT_POS_W-1:0]  committed_pos,
	output logic [trfa_pkg::OUT_POS_W-1:0]  write_pos
);

	localparam int PW = $clog2(BUF_GRANULES);
	localparam int TW = (PW + 1 > trfa_pkg::PAYLOAD_W + 1) ? PW + 1 : trfa_pkg::PAYLOAD_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DROP,
		S_CMT
	} state_t;

	state_t                             state_q;
	logic [PW-1:0]                      rp_q;
	logic [PW-1:0]                      wp_q;
	logic [PW-1:0]                      cm_q;
	logic [trfa_pkg::WRITERS_W-1:0]     wo_q;
	logic [TW-1:0]                      total_q;
	logic                               rsp_valid_q;
	trfa_pkg::status_t                  status_q;
	logic [trfa_pkg::OUT_POS_W-1:0]     frame_pos_q;
	logic [trfa_pkg::DROP_W-1:0]        drop_cnt_q;

	logic                               accept;
	logic [PW-1:0]                      cpos;
	logic [PW-1:0]                      free_c;
	logic [PW-1:0]                      free_r;
	logic [PW:0]                        room;
	logic                               refuse;
	logic                               need_drop;
	logic                               need_pad;
	logic [PW-1:0]                      sz;
	logic [PW-1:0]                      span;
	logic                               mem_we;
	logic [PW-1:0]                      mem_wdata;
	logic [PW-1:0]                      mem_raddr;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign cpos      = PW'(commit_pos);

	assign free_c    = cm_q - PW'(1) - wp_q;
	assign free_r    = rp_q - PW'(1) - wp_q;
	assign room      = (PW+1)'(BUF_GRANULES) - {1'b0, wp_q};
	assign refuse    = TW'(free_c) < total_q;
	assign need_drop = TW'(free_r) < total_q;
	assign need_pad  = TW'(room) < total_q;
	assign span      = cm_q - rp_q;

	assign mem_we    = (state_q == S_EVAL) && !refuse && !need_drop;
	assign mem_wdata = need_pad ? PW'(room) : PW'(total_q);
	assign mem_raddr = (state_q == S_IDLE) ? cpos : rp_q;

	trfa_ram #(
		.WIDTH (PW),
		.DEPTH (BUF_GRANULES)
	) u_size_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (sz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			cm_q        <= '0;
			wo_q        <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= trfa_pkg::STAT_RESERVED;
			frame_pos_q <= '0;
			drop_cnt_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !accept) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						drop_cnt_q  <= '0;
						frame_pos_q <= '0;
						total_q     <= TW'(HEADER_GRANULES) + TW'(payload_granules);
						if (action == trfa_pkg::ACT_RESERVE) begin
							if (wo_q == trfa_pkg::WRITERS_MAX) begin
								rsp_valid_q <= 1'b1;
								status_q    <= trfa_pkg::STAT_REFUSED;
							end else begin
								rsp_valid_q <= 1'b0;
								state_q     <= S_EVAL;
							end
						end else if (wo_q == '0) begin
							rsp_valid_q <= 1'b1;
							status_q    <= trfa_pkg::STAT_NO_WRITER;
						end else begin
							wo_q <= wo_q - 1'b1;
							if (wo_q == trfa_pkg::WRITERS_W'(1)) begin
								cm_q        <= wp_q;
								rsp_valid_q <= 1'b1;
								status_q    <= trfa_pkg::STAT_COMMITTED;
							end else if (cpos == cm_q) begin
								rsp_valid_q <= 1'b0;
								state_q     <= S_CMT;
							end else begin
								rsp_valid_q <= 1'b1;
								status_q    <= trfa_pkg::STAT_COMMITTED;
							end
						end
					end
				end
				S_EVAL: begin
					if (refuse) begin
						rsp_valid_q <= 1'b1;
						status_q    <= trfa_pkg::STAT_REFUSED;
						state_q     <= S_IDLE;
					end else if (need_drop) begin
						state_q <= S_DROP;
					end else if (need_pad) begin
						if (cm_q == wp_q) begin
							cm_q <= '0;
						end
						wp_q <= '0;
					end else begin
						wp_q        <= wp_q + PW'(total_q);
						wo_q        <= wo_q + 1'b1;
						frame_pos_q <= trfa_pkg::OUT_POS_W'(wp_q);
						rsp_valid_q <= 1'b1;
						status_q    <= trfa_pkg::STAT_RESERVED;
						state_q     <= S_IDLE;
					end
				end
				S_DROP: begin
					if (sz == '0 || sz > span) begin
						rp_q <= cm_q;
					end else begin
						rp_q <= rp_q + sz;
					end
					if (drop_cnt_q != trfa_pkg::DROP_MAX) begin
						drop_cnt_q <= drop_cnt_q + 1'b1;
					end
					state_q <= S_EVAL;
				end
				S_CMT: begin
					cm_q        <= cm_q + sz;
					rsp_valid_q <= 1'b1;
					status_q    <= trfa_pkg::STAT_COMMITTED;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign frame_pos      = frame_pos_q;
	assign frames_dropped = drop_cnt_q;
	assign read_pos       = trfa_pkg::OUT_POS_W'(rp_q);
	assign committed_pos  = trfa_pkg::OUT_POS_W'(cm_q);
	assign write_pos      = trfa_pkg::OUT_POS_W'(wp_q);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int BUF = trfa_pkg::BUF_GRANULES_DEF;
	localparam int HDR = trfa_pkg::HEADER_GRANULES_DEF;

	typedef struct packed {
		trfa_pkg::action_t              act;
		logic [trfa_pkg::PAYLOAD_W-1:0] pl;
		logic [trfa_pkg::OUT_POS_W-1:0] cp;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]                     st;
		logic [trfa_pkg::OUT_POS_W-1:0] pos;
		logic [trfa_pkg::DROP_W-1:0]    drops;
		logic [trfa_pkg::OUT_POS_W-1:0] rd;
		logic [trfa_pkg::OUT_POS_W-1:0] cm;
		logic [trfa_pkg::OUT_POS_W-1:0] wr;
	} alloc_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic action = trfa_pkg::ACT_RESERVE;
	logic [trfa_pkg::PAYLOAD_W-1:0] payload_granules = '0;
	logic [trfa_pkg::OUT_POS_W-1:0] commit_pos = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [1:0] status;
	logic [trfa_pkg::OUT_POS_W-1:0] frame_pos;
	logic [trfa_pkg::DROP_W-1:0] frames_dropped;
	logic [trfa_pkg::OUT_POS_W-1:0] read_pos;
	logic [trfa_pkg::OUT_POS_W-1:0] committed_pos;
	logic [trfa_pkg::OUT_POS_W-1:0] write_pos;

	logic [trfa_pkg::OUT_POS_W-1:0] rd_ptr = '0;
	logic [trfa_pkg::OUT_POS_W-1:0] wr_ptr = '0;
	logic [trfa_pkg::OUT_POS_W-1:0] cm_ptr = '0;
	logic [trfa_pkg::WRITERS_W-1:0] open_writers = '0;
	logic [trfa_pkg::PAYLOAD_W-1:0] size_mem [0:BUF-1];
	bit size_known [0:BUF-1];

	alloc_req_t pending_reqs[$];
	alloc_rsp_t predicted_rsps[$];
	logic [trfa_pkg::OUT_POS_W-1:0] open_frames[$];
	alloc_req_t cur_req;
	alloc_rsp_t granted;
	alloc_rsp_t seen;
	bit granted_blank;
	bit found;
	int k;
	int cyc = 0;
	int rsp_count = 0;
	int hold_left = 0;
	int errors = 0;

	always #4 clk = ~clk;

	trace_ring_frame_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.payload_granules(payload_granules),
		.commit_pos(commit_pos),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.frame_pos(frame_pos),
		.frames_dropped(frames_dropped),
		.read_pos(read_pos),
		.committed_pos(committed_pos),
		.write_pos(write_pos)
	);

	// In a trial step the allocator state is restored afterwards and
	// touches_blank tells whether a size entry never written would be read.
	task automatic allocate_step(input bit trial, input alloc_req_t rq, output alloc_rsp_t rs,
			output bit touches_blank);
		logic [trfa_pkg::OUT_POS_W-1:0] rd0, wr0, cm0, gap, pad_at;
		logic [trfa_pkg::WRITERS_W-1:0] wo0;
		logic [trfa_pkg::PAYLOAD_W-1:0] sz, pad_old;
		bit pad_old_known, padded, finished;
		int total, drops;
		begin
			rd0 = rd_ptr;
			wr0 = wr_ptr;
			cm0 = cm_ptr;
			wo0 = open_writers;
			pad_at = '0;
			pad_old = '0;
			pad_old_known = 1'b0;
			touches_blank = 1'b0;
			padded = 1'b0;
			finished = 1'b0;
			drops = 0;
			total = HDR + int'(rq.pl);
			rs = '0;
			if (rq.act == trfa_pkg::ACT_COMMIT) begin
				rs.st = trfa_pkg::STAT_NO_WRITER;
				if (open_writers != 0) begin
					open_writers--;
					rs.st = trfa_pkg::STAT_COMMITTED;
					if (open_writers == 0)
						cm_ptr = wr_ptr;
					else if (rq.cp == cm_ptr) begin
						touches_blank = !size_known[rq.cp];
						cm_ptr = trfa_pkg::OUT_POS_W'(cm_ptr + size_mem[rq.cp]);
					end
				end
			end else if (open_writers == trfa_pkg::WRITERS_MAX) begin
				rs.st = trfa_pkg::STAT_REFUSED;
			end else begin
				while (!finished) begin
					gap = cm_ptr - 10'd1 - wr_ptr;
					if (int'(gap) < total) begin
						rs.st = trfa_pkg::STAT_REFUSED;
						finished = 1'b1;
					end else begin
						gap = rd_ptr - 10'd1 - wr_ptr;
						if (int'(gap) < total) begin
							touches_blank |= !size_known[rd_ptr];
							sz = size_mem[rd_ptr];
							gap = cm_ptr - rd_ptr;
							if (sz == 0 || sz > gap)
								rd_ptr = cm_ptr;
							else
								rd_ptr = trfa_pkg::OUT_POS_W'(rd_ptr + sz);
							if (drops < int'(trfa_pkg::DROP_MAX))
								drops++;
						end else if (BUF - int'(wr_ptr) < total) begin
							pad_at = wr_ptr;
							pad_old = size_mem[wr_ptr];
							pad_old_known = size_known[wr_ptr];
							padded = 1'b1;
							size_mem[wr_ptr] = trfa_pkg::PAYLOAD_W'(BUF - int'(wr_ptr));
							size_known[wr_ptr] = 1'b1;
							if (cm_ptr == wr_ptr)
								cm_ptr = '0;
							wr_ptr = '0;
						end else begin
							rs.st = trfa_pkg::STAT_RESERVED;
							rs.pos = wr_ptr;
							if (!trial) begin
								size_mem[wr_ptr] = trfa_pkg::PAYLOAD_W'(total);
								size_known[wr_ptr] = 1'b1;
							end
							wr_ptr = trfa_pkg::OUT_POS_W'(wr_ptr + total);
							open_writers++;
							finished = 1'b1;
						end
					end
				end
				rs.drops = trfa_pkg::DROP_W'(drops);
			end
			rs.rd = rd_ptr;
			rs.cm = cm_ptr;
			rs.wr = wr_ptr;
			if (trial) begin
				rd_ptr = rd0;
				wr_ptr = wr0;
				cm_ptr = cm0;
				open_writers = wo0;
				if (padded) begin
					size_mem[pad_at] = pad_old;
					size_known[pad_at] = pad_old_known;
				end
			end
		end
	endtask

	task automatic wait_slot();
		do @(negedge clk); while (pending_reqs.size() != 0 || req_valid);
	endtask

	task automatic offer_request(input trfa_pkg::action_t act,
			input logic [trfa_pkg::PAYLOAD_W-1:0] pl,
			input logic [trfa_pkg::OUT_POS_W-1:0] cp);
		alloc_req_t rq;
		alloc_rsp_t dry;
		bit blank;
		begin
			rq.act = act;
			rq.pl = pl;
			rq.cp = cp;
			allocate_step(1'b1, rq, dry, blank);
			// swap for a commit off the committed mark, which reads no size
			if (blank) begin
				rq.act = trfa_pkg::ACT_COMMIT;
				rq.cp = cm_ptr + 10'd1;
			end
			pending_reqs.push_back(rq);
		end
	endtask

	task automatic send_directed(input trfa_pkg::action_t act,
			input logic [trfa_pkg::PAYLOAD_W-1:0] pl,
			input logic [trfa_pkg::OUT_POS_W-1:0] cp);
		wait_slot();
		offer_request(act, pl, cp);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	function automatic bit lazy();
		return !(cyc >= 3000 && cyc < 6000) && $urandom_range(99) < 20;
	endfunction

	always @(posedge clk)
		cyc <= cyc + 1;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (req_valid) begin
				allocate_step(1'b0, cur_req, granted, granted_blank);
				predicted_rsps.push_back(granted);
				if (granted.st == trfa_pkg::STAT_RESERVED) begin
					open_frames.push_back(granted.pos);
				end else if (granted.st == trfa_pkg::STAT_COMMITTED) begin
					found = 1'b0;
					for (k = 0; k < open_frames.size(); k++)
						if (!found && open_frames[k] == cur_req.cp) begin
							open_frames.delete(k);
							found = 1'b1;
						end
				end
				if (open_writers == 0)
					open_frames.delete();
			end
			if (pending_reqs.size() != 0 && !lazy()) begin
				cur_req = pending_reqs.pop_front();
				req_valid <= 1'b1;
				action <= cur_req.act;
				payload_granules <= cur_req.pl;
				commit_pos <= cur_req.cp;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsps.size() == 0) begin
					$display("%0t: response with none expected: expected none, actual status %0d",
						$time, status);
					errors++;
				end else begin
					seen = predicted_rsps.pop_front();
					check_field("status", seen.st, status);
					check_field("frame_pos", seen.pos, frame_pos);
					check_field("frames_dropped", seen.drops, frames_dropped);
					check_field("read_pos", seen.rd, read_pos);
					check_field("committed_pos", seen.cm, committed_pos);
					check_field("write_pos", seen.wr, write_pos);
				end
				rsp_count++;
				if (rsp_count == 1200)
					hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= !lazy();
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int n, pick, flood_at;
		trfa_pkg::action_t act;
		logic [trfa_pkg::PAYLOAD_W-1:0] pl;
		logic [trfa_pkg::OUT_POS_W-1:0] cp;
		for (n = 0; n < BUF; n++)
			size_mem[n] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'h3FF);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd0, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd1024, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd1019, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd1018, 10'd0);
		send_directed(trfa_pkg::ACT_COMMIT, 11'h7FF, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd1015, 10'd0);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'd4);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd100, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd20, 10'd0);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'd0);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'h155);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'h2AA);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd512, 10'd0);
		send_directed(trfa_pkg::ACT_RESERVE, 11'd255, 10'd0);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'd128);
		send_directed(trfa_pkg::ACT_COMMIT, 11'd0, 10'd644);

		flood_at = $urandom_range(400, 900);
		for (n = 0; n < 2000; n++) begin
			wait_slot();
			// drain, then fill the writer count with minimal frames
			if (n == flood_at) begin
				while (open_writers != 0) begin
					offer_request(trfa_pkg::ACT_COMMIT, 11'd0,
						open_frames.size() != 0 ? open_frames[0] : cm_ptr + 10'd1);
					wait_slot();
				end
				repeat (256) begin
					offer_request(trfa_pkg::ACT_RESERVE, 11'd0, 10'd0);
					wait_slot();
				end
			end
			pick = $urandom_range(99);
			cp = 10'($urandom_range(BUF - 1));
			if (pick < 70) begin
				if (open_frames.size() != 0 &&
						($urandom_range(99) < 45 || open_frames.size() >= 6)) begin
					act = trfa_pkg::ACT_COMMIT;
					pl = 11'($urandom_range(2047));
					if ($urandom_range(3) == 0)
						cp = open_frames[$urandom_range(open_frames.size() - 1)];
					else
						cp = open_frames[0];
				end else begin
					act = trfa_pkg::ACT_RESERVE;
					pick = $urandom_range(99);
					if (pick < 70)
						pl = 11'($urandom_range(40));
					else if (pick < 95)
						pl = 11'($urandom_range(300, 41));
					else
						pl = 11'($urandom_range(1024, 301));
				end
			end else begin
				act = ($urandom_range(1) != 0) ? trfa_pkg::ACT_COMMIT : trfa_pkg::ACT_RESERVE;
				pl = 11'($urandom_range(1024));
				if ($urandom_range(1) != 0)
					cp = cm_ptr;
			end
			offer_request(act, pl, cp);
		end

		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/trfa_pkg.sv
hw/rtl/trfa_ram.sv
hw/rtl/trace_ring_frame_allocator.sv
verif/tb.sv
